### hdl/lobm_pkg.sv
// Package: shared types and constants of the order book matcher.
package lobm_pkg;

  localparam int unsigned BookOrdersDefault = 32;
  localparam int unsigned CmdQueueDepth     = 2;

  localparam logic CmdSubmit = 1'b0;
  localparam logic CmdCancel = 1'b1;

  localparam logic KindTrade  = 1'b0;
  localparam logic KindStatus = 1'b1;

  localparam logic [2:0] StAccepted  = 3'd0;
  localparam logic [2:0] StDuplicate = 3'd1;
  localparam logic [2:0] StCancelled = 3'd2;
  localparam logic [2:0] StNotFound  = 3'd3;
  localparam logic [2:0] StBookFull  = 3'd4;

  typedef struct packed {
    logic        command;
    logic [31:0] order_ref;
    logic        side;
    logic [31:0] limit_price;
    logic [31:0] order_quantity;
  } cmd_t;

  typedef struct packed {
    logic        item_kind;
    logic [2:0]  status;
    logic [31:0] trade_number;
    logic [31:0] buyer_id;
    logic [31:0] seller_id;
    logic [31:0] trade_price;
    logic [31:0] trade_quantity;
    logic        aggressor_side;
    logic        last;
  } res_t;

endpackage

### hdl/lobm_if.sv
// Interfaces: command and result channels with valid/ready handshake.
interface lobm_cmd_if import lobm_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lobm_res_if import lobm_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/lobm_front.sv
// Front end: accept command transactions into a short queue.
module lobm_front import lobm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  lobm_cmd_if.sink   in_ch,
  lobm_cmd_if.source q_ch
);
  localparam int unsigned AW = $clog2(CmdQueueDepth);

  cmd_t            mem_r [CmdQueueDepth];
  logic [AW-1:0]   wp_r, rp_r;
  logic [AW:0]     cnt_r;
  logic            push, pop;

  assign in_ch.ready = (cnt_r != (AW+1)'(CmdQueueDepth));
  assign q_ch.valid  = (cnt_r != '0);
  assign q_ch.data   = mem_r[rp_r];
  assign push = in_ch.valid && in_ch.ready;
  assign pop  = q_ch.valid && q_ch.ready;

  // Store payload
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_ch.data;
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(CmdQueueDepth-1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == AW'(CmdQueueDepth-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

### hdl/lobm_back.sv
// Back end: book storage, slot scan sequencer and result register.
module lobm_back import lobm_pkg::*; #(
  parameter int unsigned BOOK_ORDERS = BookOrdersDefault
) (
  input  logic clk,
  input  logic rst_n,
  lobm_cmd_if.sink   q_ch,
  lobm_res_if.source out_ch
);
  localparam int unsigned SW = $clog2(BOOK_ORDERS);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_FILL = 5'b00100,
    S_EMIT = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state_r;

  logic [BOOK_ORDERS-1:0] valid_r;
  logic [31:0] id_m    [BOOK_ORDERS];
  logic        side_m  [BOOK_ORDERS];
  logic [31:0] price_m [BOOK_ORDERS];
  logic [31:0] qty_m   [BOOK_ORDERS];
  logic [31:0] arr_m   [BOOK_ORDERS];
  logic [31:0] arrival_r, trade_r;

  cmd_t        cmd_r;
  logic [31:0] rem_r;
  logic [SW:0] idx_r;
  logic        dup_r, hit_r, best_ok_r, free_ok_r;
  logic [SW-1:0] hit_slot_r, best_r, free_r;
  logic [31:0] best_price_r, best_age_r;
  logic [6:0]  ntr_r;
  res_t        res_r;
  logic        res_v_r;

  logic [SW-1:0] ix;
  logic          v_i, match_i, lim_ok, better;
  logic [31:0]   age_i, fill_q;
  logic          scan_end;
  logic          do_trade, res_load;
  res_t          fill_res;

  assign ix       = idx_r[SW-1:0];
  assign v_i      = valid_r[ix];
  assign age_i    = arrival_r - arr_m[ix];
  assign lim_ok   = cmd_r.side ? (price_m[ix] >= cmd_r.limit_price)
                               : (price_m[ix] <= cmd_r.limit_price);
  assign match_i  = v_i && (side_m[ix] != cmd_r.side) && lim_ok;
  assign better   = !best_ok_r ||
                    ((price_m[ix] == best_price_r) ? (age_i > best_age_r) :
                     (cmd_r.side ? (price_m[ix] > best_price_r)
                                 : (price_m[ix] < best_price_r)));
  assign scan_end = (idx_r == (SW+1)'(BOOK_ORDERS-1));
  assign fill_q   = (rem_r < qty_m[best_r]) ? rem_r : qty_m[best_r];
  assign do_trade = (rem_r != '0) && best_ok_r && (ntr_r != 7'(BOOK_ORDERS));
  assign res_load = (state_r == S_FILL) && (!res_v_r || out_ch.ready);

  assign q_ch.ready   = (state_r == S_IDLE);
  assign out_ch.valid = res_v_r;
  assign out_ch.data  = res_r;

  // Build the result transaction for the fill step
  always_comb begin
    fill_res           = '0;
    fill_res.item_kind = KindStatus;
    fill_res.last      = 1'b1;
    if (cmd_r.command == CmdCancel) begin
      fill_res.status = hit_r ? StCancelled : StNotFound;
    end else if (dup_r) begin
      fill_res.status = StDuplicate;
    end else if (do_trade) begin
      fill_res.item_kind      = KindTrade;
      fill_res.last           = 1'b0;
      fill_res.trade_number   = trade_r;
      fill_res.buyer_id       = cmd_r.side ? id_m[best_r] : cmd_r.order_ref;
      fill_res.seller_id      = cmd_r.side ? cmd_r.order_ref : id_m[best_r];
      fill_res.trade_price    = price_m[best_r];
      fill_res.trade_quantity = fill_q;
      fill_res.aggressor_side = cmd_r.side;
    end else if (rem_r != '0 && !free_ok_r) begin
      fill_res.status = StBookFull;
    end else begin
      fill_res.status = StAccepted;
    end
  end

  // Sequencer: one slot per cycle scan, then fill or finish
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      valid_r   <= '0;
      arrival_r <= '0;
      trade_r   <= '0;
      res_v_r   <= 1'b0;
    end else begin
      if (res_load) res_v_r <= 1'b1;
      else if (res_v_r && out_ch.ready) res_v_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (q_ch.valid) begin
          cmd_r <= q_ch.data;
          rem_r <= q_ch.data.order_quantity;
          ntr_r <= '0;
          idx_r <= '0;
          dup_r <= 1'b0; hit_r <= 1'b0; best_ok_r <= 1'b0; free_ok_r <= 1'b0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (v_i && id_m[ix] == cmd_r.order_ref) begin
            dup_r <= 1'b1; hit_r <= 1'b1; hit_slot_r <= ix;
          end
          if (!v_i && !free_ok_r) begin
            free_ok_r <= 1'b1; free_r <= ix;
          end
          if (match_i && better) begin
            best_ok_r <= 1'b1; best_r <= ix;
            best_price_r <= price_m[ix]; best_age_r <= age_i;
          end
          idx_r <= idx_r + 1'b1;
          if (scan_end) state_r <= S_FILL;
        end
        S_FILL: if (res_load) begin
          res_r <= fill_res;
          if (cmd_r.command == CmdCancel) begin
            if (hit_r) valid_r[hit_slot_r] <= 1'b0;
            state_r <= S_DONE;
          end else if (dup_r) begin
            state_r <= S_DONE;
          end else if (do_trade) begin
            trade_r <= trade_r + 1'b1;
            rem_r   <= rem_r - fill_q;
            qty_m[best_r] <= qty_m[best_r] - fill_q;
            if (qty_m[best_r] == fill_q) valid_r[best_r] <= 1'b0;
            ntr_r <= ntr_r + 1'b1;
            state_r <= S_EMIT;
          end else begin
            // Rest the remainder in the lowest free slot
            if (rem_r != '0 && free_ok_r) begin
              valid_r[free_r] <= 1'b1;
              id_m[free_r]    <= cmd_r.order_ref;
              side_m[free_r]  <= cmd_r.side;
              price_m[free_r] <= cmd_r.limit_price;
              qty_m[free_r]   <= rem_r;
              arr_m[free_r]   <= arrival_r;
              arrival_r <= arrival_r + 1'b1;
            end
            state_r <= S_DONE;
          end
        end
        S_EMIT: begin
          idx_r <= '0; best_ok_r <= 1'b0; free_ok_r <= 1'b0;
          state_r <= S_SCAN;
        end
        S_DONE: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

### hdl/limit_order_book_matcher_top.sv
// A full slot scan of the book storage precedes each trade and the final status
// of a command, after the command passes through the front end queue.
// The back end scans one slot per cycle and takes a new command only after
// the previous one is finished; the front end queue holds waiting commands.
// Reset: synchronous active-low rst_n empties the book and zeroes counters.
module limit_order_book_matcher_top import lobm_pkg::*; #(
  parameter int unsigned BOOK_ORDERS = BookOrdersDefault
) (
  input  logic clk,
  input  logic rst_n,
  lobm_cmd_if.sink   in_ch,
  lobm_res_if.source out_ch
);
  lobm_cmd_if q_ch ();

  // Front end queue
  lobm_front u_front (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .q_ch(q_ch));

  // Matching engine
  lobm_back #(.BOOK_ORDERS(BOOK_ORDERS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_ch(q_ch), .out_ch(out_ch)
  );
endmodule
